/* hw/rtl/pwcs_pkg.sv */
package pwcs_pkg;

    localparam int TIMER_WIDTH_DEF      = 16;
    localparam int BITS_PER_COMMAND_DEF = 8;

    localparam int DUR_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_START_HIGH = 3'd0,
        REG_START_LOW  = 3'd1,
        REG_LONG       = 3'd2,
        REG_SHORT      = 3'd3,
        REG_STOP       = 3'd4
    } cfg_index_t;

    localparam logic [DUR_W-1:0] START_HIGH_RST = 16'd500;
    localparam logic [DUR_W-1:0] START_LOW_RST  = 16'd500;
    localparam logic [DUR_W-1:0] LONG_RST       = 16'd60;
    localparam logic [DUR_W-1:0] SHORT_RST      = 16'd20;
    localparam logic [DUR_W-1:0] STOP_RST       = 16'd400;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_WAIT       = 3'd1,
        PH_START_HIGH = 3'd2,
        PH_START_LOW  = 3'd3,
        PH_BIT_HIGH   = 3'd4,
        PH_BIT_LOW    = 3'd5,
        PH_STOP       = 3'd6
    } phase_t;

    typedef struct packed {
        logic              send_request;
        logic [BYTE_W-1:0] command_byte;
        logic              player_idle;
    } cmd_in_t;

    typedef struct packed {
        logic line_level;
        logic ready_res;
        logic finished;
    } cmd_out_t;

    typedef struct packed {
        logic [DUR_W-1:0] start_high_ticks;
        logic [DUR_W-1:0] start_low_ticks;
        logic [DUR_W-1:0] long_ticks;
        logic [DUR_W-1:0] short_ticks;
        logic [DUR_W-1:0] stop_ticks;
    } timing_cfg_t;

endpackage

/* hw/rtl/pwcs_cfg_regs.sv */
module pwcs_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [pwcs_pkg::INDEX_W-1:0] wr_index,
    input  logic [pwcs_pkg::DUR_W-1:0]   wr_data,
    output pwcs_pkg::timing_cfg_t        cfg
);

    pwcs_pkg::timing_cfg_t cfg_reg;
    pwcs_pkg::timing_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (pwcs_pkg::cfg_index_t'(wr_index))
                pwcs_pkg::REG_START_HIGH: cfg_next.start_high_ticks = wr_data;
                pwcs_pkg::REG_START_LOW:  cfg_next.start_low_ticks  = wr_data;
                pwcs_pkg::REG_LONG:       cfg_next.long_ticks       = wr_data;
                pwcs_pkg::REG_SHORT:      cfg_next.short_ticks      = wr_data;
                pwcs_pkg::REG_STOP:       cfg_next.stop_ticks       = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_high_ticks <= pwcs_pkg::START_HIGH_RST;
            cfg_reg.start_low_ticks  <= pwcs_pkg::START_LOW_RST;
            cfg_reg.long_ticks       <= pwcs_pkg::LONG_RST;
            cfg_reg.short_ticks      <= pwcs_pkg::SHORT_RST;
            cfg_reg.stop_ticks       <= pwcs_pkg::STOP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/pwcs_seq.sv */
module pwcs_seq #(
    parameter int TIMER_WIDTH      = pwcs_pkg::TIMER_WIDTH_DEF,
    parameter int BITS_PER_COMMAND = pwcs_pkg::BITS_PER_COMMAND_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  pwcs_pkg::cmd_in_t     item,
    input  pwcs_pkg::timing_cfg_t cfg,
    output pwcs_pkg::cmd_out_t    result
);

    localparam int CNT_W = (BITS_PER_COMMAND > 1) ? $clog2(BITS_PER_COMMAND) : 1;

    pwcs_pkg::phase_t               phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]         timer_reg, timer_next;
    logic [pwcs_pkg::BYTE_W-1:0]    shift_reg, shift_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           line_reg, line_next;
    logic                           fin;
    logic                           expired;
    logic                           last_bit;
    logic [TIMER_WIDTH-1:0]         load_start_high;
    logic [TIMER_WIDTH-1:0]         load_start_low;
    logic [TIMER_WIDTH-1:0]         load_long;
    logic [TIMER_WIDTH-1:0]         load_short;
    logic [TIMER_WIDTH-1:0]         load_stop;

    // ticks left after the first one, saturated to the timer
    function automatic logic [TIMER_WIDTH-1:0] ticks_left(input logic [pwcs_pkg::DUR_W-1:0] dur);
        logic [pwcs_pkg::DUR_W-1:0] left;
        logic [TIMER_WIDTH-1:0]     res;
        left = (dur == '0) ? '0 : dur - pwcs_pkg::DUR_W'(1);
        if ((32'(left) >> TIMER_WIDTH) != 32'd0) begin
            res = '1;
        end else begin
            res = TIMER_WIDTH'(left);
        end
        return res;
    endfunction

    assign load_start_high = ticks_left(cfg.start_high_ticks);
    assign load_start_low  = ticks_left(cfg.start_low_ticks);
    assign load_long       = ticks_left(cfg.long_ticks);
    assign load_short      = ticks_left(cfg.short_ticks);
    assign load_stop       = ticks_left(cfg.stop_ticks);

    assign expired  = (timer_reg == '0);
    assign last_bit = ((CNT_W+1)'(count_reg) + (CNT_W+1)'(1))
                      >= (CNT_W+1)'(BITS_PER_COMMAND);

    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        line_next  = line_reg;
        fin        = 1'b0;
        case (phase_reg)
            pwcs_pkg::PH_IDLE: begin
                if (item.send_request) begin
                    shift_next = item.command_byte;
                    count_next = '0;
                    if (item.player_idle) begin
                        phase_next = pwcs_pkg::PH_START_HIGH;
                        timer_next = load_start_high;
                        line_next  = 1'b1;
                    end else begin
                        phase_next = pwcs_pkg::PH_WAIT;
                    end
                end
            end
            pwcs_pkg::PH_WAIT: begin
                if (item.player_idle) begin
                    phase_next = pwcs_pkg::PH_START_HIGH;
                    timer_next = load_start_high;
                    line_next  = 1'b1;
                end
            end
            pwcs_pkg::PH_START_HIGH: begin
                if (expired) begin
                    phase_next = pwcs_pkg::PH_START_LOW;
                    timer_next = load_start_low;
                    line_next  = 1'b0;
                end else begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
            end
            pwcs_pkg::PH_START_LOW: begin
                if (expired) begin
                    phase_next = pwcs_pkg::PH_BIT_HIGH;
                    timer_next = shift_reg[0] ? load_long : load_short;
                    line_next  = 1'b1;
                end else begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
            end
            pwcs_pkg::PH_BIT_HIGH: begin
                if (expired) begin
                    phase_next = pwcs_pkg::PH_BIT_LOW;
                    timer_next = shift_reg[0] ? load_short : load_long;
                    line_next  = 1'b0;
                end else begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
            end
            pwcs_pkg::PH_BIT_LOW: begin
                if (expired) begin
                    shift_next = shift_reg >> 1;
                    line_next  = 1'b1;
                    if (last_bit) begin
                        phase_next = pwcs_pkg::PH_STOP;
                        timer_next = load_stop;
                    end else begin
                        phase_next = pwcs_pkg::PH_BIT_HIGH;
                        count_next = count_reg + CNT_W'(1);
                        timer_next = shift_reg[1] ? load_long : load_short;
                    end
                end else begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
            end
            pwcs_pkg::PH_STOP: begin
                if (expired) begin
                    phase_next = pwcs_pkg::PH_IDLE;
                    timer_next = '0;
                    count_next = '0;
                    fin        = 1'b1;
                end else begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
            end
            default: begin
                phase_next = pwcs_pkg::PH_IDLE;
                timer_next = '0;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pwcs_pkg::PH_IDLE;
            timer_reg <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            line_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            line_reg  <= line_next;
        end
    end

    assign result.line_level = line_next;
    assign result.ready_res  = (phase_next == pwcs_pkg::PH_IDLE);
    assign result.finished   = fin;

endmodule

/* hw/rtl/pulse_width_command_sender.sv */
// Pulse-width command sender: each input beat is one timebase tick carrying a
// send request, the command byte and the player's idle level; each tick gives
// exactly one result beat with the data line level, a ready flag and a
// finished pulse. Durations of the start frame, bit phases and stop period are
// tick counts in five 16-bit registers (index 0 start high, 1 start low,
// 2 long, 3 short, 4 stop); write them only while no command is in progress.
// One tick is taken every clock cycle while the sink takes results; a tick is
// held in the input register, then moves to the result register, from which
// its result beat is offered, and the phase state advances when it moves. A
// result beat held by the sink stalls the input in turn.
module pulse_width_command_sender #(
    parameter int TIMER_WIDTH      = pwcs_pkg::TIMER_WIDTH_DEF,
    parameter int BITS_PER_COMMAND = pwcs_pkg::BITS_PER_COMMAND_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pwcs_pkg::cmd_in_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pwcs_pkg::cmd_out_t           m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pwcs_pkg::INDEX_W-1:0] cfg_index,
    input  logic [pwcs_pkg::DUR_W-1:0]   cfg_data
);

    logic                  in_valid_reg;
    pwcs_pkg::cmd_in_t     in_data_reg;
    logic                  out_valid_reg;
    pwcs_pkg::cmd_out_t    out_data_reg;
    logic                  advance;
    pwcs_pkg::timing_cfg_t cfg;
    pwcs_pkg::cmd_out_t    result;

    assign cfg_ready = 1'b1;

    pwcs_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // tick moves from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pwcs_seq #(
        .TIMER_WIDTH      (TIMER_WIDTH),
        .BITS_PER_COMMAND (BITS_PER_COMMAND)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* sim/tb_pulse_width_command_sender.sv */
module tb_pulse_width_command_sender;

    typedef struct {
        pwcs_pkg::cmd_in_t  tick;
        int                 reps;
        logic               fixed;
        pwcs_pkg::cmd_out_t res;
    } tick_row_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    pwcs_pkg::cmd_in_t            s_data    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    pwcs_pkg::cmd_out_t           m_data;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [pwcs_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [pwcs_pkg::DUR_W-1:0]   cfg_data  = '0;

    // mirror of the sender: timing registers and line state
    pwcs_pkg::timing_cfg_t        timing = '{pwcs_pkg::START_HIGH_RST, pwcs_pkg::START_LOW_RST,
                                             pwcs_pkg::LONG_RST, pwcs_pkg::SHORT_RST,
                                             pwcs_pkg::STOP_RST};
    pwcs_pkg::phase_t             line_phase  = pwcs_pkg::PH_IDLE;
    logic [pwcs_pkg::DUR_W-1:0]   ticks_left  = '0;
    logic [pwcs_pkg::BYTE_W-1:0]  shift_bits  = '0;
    logic [3:0]                   bits_sent   = '0;
    logic                         line_hold   = 1'b0;

    pwcs_pkg::cmd_out_t           levels_due[$];
    pwcs_pkg::cmd_out_t           level_want;
    int unsigned                  mismatches  = 0;
    int unsigned                  ticks_sent  = 0;
    bit                           steady_flow = 1'b0;

    // typed rows use timing 1/0/2/0/1; 0xff goes out as three ticks per bit
    tick_row_t opening_ticks [8] = '{
        '{'{1'b0, 8'h00, 1'b1},  1, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{'{1'b1, 8'hFF, 1'b0},  1, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{'{1'b1, 8'h00, 1'b0},  2, 1'b1, '{1'b0, 1'b0, 1'b0}},
        '{'{1'b0, 8'h00, 1'b1},  1, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{'{1'b1, 8'h00, 1'b0}, 26, 1'b0, '0},
        '{'{1'b0, 8'h5A, 1'b1},  1, 1'b1, '{1'b1, 1'b1, 1'b1}},
        '{'{1'b0, 8'h00, 1'b0},  1, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{'{1'b1, 8'h00, 1'b1},  1, 1'b1, '{1'b1, 1'b0, 1'b0}}
    };

    pulse_width_command_sender u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #400_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void enter_line_phase(input pwcs_pkg::phase_t p,
                                             input logic [pwcs_pkg::DUR_W-1:0] dur,
                                             input logic lvl);
        line_phase = p;
        ticks_left = (dur == '0) ? '0 : dur - 1'b1;
        line_hold  = lvl;
    endfunction

    function automatic pwcs_pkg::cmd_out_t advance_pulse_line(input pwcs_pkg::cmd_in_t t);
        pwcs_pkg::cmd_out_t o;
        logic               done;
        logic               expired;
        done    = 1'b0;
        expired = (ticks_left == '0);
        case (line_phase)
            pwcs_pkg::PH_IDLE: begin
                if (t.send_request) begin
                    shift_bits = t.command_byte;
                    bits_sent  = '0;
                    if (t.player_idle)
                        enter_line_phase(pwcs_pkg::PH_START_HIGH, timing.start_high_ticks,
                                         1'b1);
                    else
                        line_phase = pwcs_pkg::PH_WAIT;
                end
            end
            pwcs_pkg::PH_WAIT: begin
                if (t.player_idle)
                    enter_line_phase(pwcs_pkg::PH_START_HIGH, timing.start_high_ticks, 1'b1);
            end
            pwcs_pkg::PH_START_HIGH: begin
                if (expired)
                    enter_line_phase(pwcs_pkg::PH_START_LOW, timing.start_low_ticks, 1'b0);
                else
                    ticks_left--;
            end
            pwcs_pkg::PH_START_LOW: begin
                if (expired)
                    enter_line_phase(pwcs_pkg::PH_BIT_HIGH,
                                     shift_bits[0] ? timing.long_ticks : timing.short_ticks,
                                     1'b1);
                else
                    ticks_left--;
            end
            pwcs_pkg::PH_BIT_HIGH: begin
                if (expired)
                    enter_line_phase(pwcs_pkg::PH_BIT_LOW,
                                     shift_bits[0] ? timing.short_ticks : timing.long_ticks,
                                     1'b0);
                else
                    ticks_left--;
            end
            pwcs_pkg::PH_BIT_LOW: begin
                if (expired) begin
                    shift_bits = shift_bits >> 1;
                    if (int'(bits_sent) + 1 >= pwcs_pkg::BITS_PER_COMMAND_DEF) begin
                        enter_line_phase(pwcs_pkg::PH_STOP, timing.stop_ticks, 1'b1);
                    end else begin
                        bits_sent++;
                        enter_line_phase(pwcs_pkg::PH_BIT_HIGH,
                                         shift_bits[0] ? timing.long_ticks
                                                       : timing.short_ticks, 1'b1);
                    end
                end else begin
                    ticks_left--;
                end
            end
            pwcs_pkg::PH_STOP: begin
                if (expired) begin
                    line_phase = pwcs_pkg::PH_IDLE;
                    ticks_left = '0;
                    bits_sent  = '0;
                    done       = 1'b1;
                end else begin
                    ticks_left--;
                end
            end
            default: begin
                line_phase = pwcs_pkg::PH_IDLE;
                ticks_left = '0;
                bits_sent  = '0;
            end
        endcase
        o.line_level = line_hold;
        o.ready_res  = (line_phase == pwcs_pkg::PH_IDLE);
        o.finished   = done;
        return o;
    endfunction

    // mostly back to back, some short gaps, a few long ones; none while steady_flow is set
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [pwcs_pkg::DUR_W-1:0] random_dur();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 80)
            return pwcs_pkg::DUR_W'($urandom_range(1, 4));
        if (r < 97)
            return pwcs_pkg::DUR_W'($urandom_range(5, 24));
        return pwcs_pkg::DUR_W'($urandom_range(25, 200));
    endfunction

    function automatic pwcs_pkg::cmd_in_t random_tick();
        pwcs_pkg::cmd_in_t t;
        t.send_request = ($urandom_range(0, 99) < 60);
        t.command_byte = pwcs_pkg::BYTE_W'($urandom);
        t.player_idle  = ($urandom_range(0, 99) < 75);
        return t;
    endfunction

    task automatic send_tick(input pwcs_pkg::cmd_in_t t, input logic fixed,
                             input pwcs_pkg::cmd_out_t fixed_res);
        int unsigned        gap;
        pwcs_pkg::cmd_out_t res;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        res = advance_pulse_line(t);
        levels_due.push_back(fixed ? fixed_res : res);
        ticks_sent++;
    endtask

    task automatic finish_command();
        while (line_phase != pwcs_pkg::PH_IDLE)
            send_tick(random_tick(), 1'b0, '0);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (levels_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pwcs_pkg::INDEX_W-1:0] idx,
                             input logic [pwcs_pkg::DUR_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pwcs_pkg::REG_START_HIGH: timing.start_high_ticks = v;
            pwcs_pkg::REG_START_LOW:  timing.start_low_ticks  = v;
            pwcs_pkg::REG_LONG:       timing.long_ticks       = v;
            pwcs_pkg::REG_SHORT:      timing.short_ticks      = v;
            pwcs_pkg::REG_STOP:       timing.stop_ticks       = v;
            default: ;
        endcase
    endtask

    task automatic apply_timing(input pwcs_pkg::timing_cfg_t c);
        write_reg(pwcs_pkg::REG_START_HIGH, c.start_high_ticks);
        write_reg(pwcs_pkg::REG_START_LOW, c.start_low_ticks);
        write_reg(pwcs_pkg::REG_LONG, c.long_ticks);
        write_reg(pwcs_pkg::REG_SHORT, c.short_ticks);
        write_reg(pwcs_pkg::REG_STOP, c.stop_ticks);
        // unused index, must leave every register alone
        write_reg(pwcs_pkg::INDEX_W'($urandom_range(2**pwcs_pkg::INDEX_W - 1,
                                                    int'(pwcs_pkg::REG_STOP) + 1)),
                  pwcs_pkg::DUR_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned gap;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            gap = pick_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (levels_due.size() == 0) begin
                $error("result beat with nothing expected: %b", m_data);
                mismatches++;
            end else begin
                level_want = levels_due.pop_front();
                if (m_data.line_level !== level_want.line_level) begin
                    $error("line_level: expected %0b, got %0b", level_want.line_level,
                           m_data.line_level);
                    mismatches++;
                end
                if (m_data.ready_res !== level_want.ready_res) begin
                    $error("ready_res: expected %0b, got %0b", level_want.ready_res,
                           m_data.ready_res);
                    mismatches++;
                end
                if (m_data.finished !== level_want.finished) begin
                    $error("finished: expected %0b, got %0b", level_want.finished,
                           m_data.finished);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        pwcs_pkg::timing_cfg_t c;
        int unsigned           n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        apply_timing('{16'd1, 16'd0, 16'd2, 16'd0, 16'd1});
        foreach (opening_ticks[i])
            repeat (opening_ticks[i].reps)
                send_tick(opening_ticks[i].tick, opening_ticks[i].fixed, opening_ticks[i].res);
        finish_command();
        settle();

        // long start and stop phases, one command with no idling
        steady_flow = 1'b1;
        apply_timing('{16'd150, 16'd150, 16'd1, 16'd0, 16'd150});
        send_tick('{1'b1, pwcs_pkg::BYTE_W'($urandom), 1'b1}, 1'b0, '0);
        finish_command();
        settle();

        while (ticks_sent < 1150) begin
            c.start_high_ticks = random_dur();
            c.start_low_ticks  = random_dur();
            c.long_ticks       = random_dur();
            c.short_ticks      = random_dur();
            c.stop_ticks       = random_dur();
            apply_timing(c);
            steady_flow = ($urandom_range(0, 3) == 0);
            n = $urandom_range(120, 220);
            for (int i = 0; i < n; i++) begin
                if (i == n / 2) begin
                    s_valid <= 1'b0;
                    while (levels_due.size() != 0) @(posedge aclk);
                end
                send_tick(random_tick(), 1'b0, '0);
            end
            finish_command();
            settle();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/pwcs_pkg.sv
hw/rtl/pwcs_cfg_regs.sv
hw/rtl/pwcs_seq.sv
hw/rtl/pulse_width_command_sender.sv
sim/tb_pulse_width_command_sender.sv
